// File: design/mau_pkg.sv
// mau_pkg: types, operation codes and widths for the modular arithmetic unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mau_pkg;

   localparam int MOD_W = 31;
   localparam int A_W   = 64;
   localparam int B_W   = 63;
   localparam int KIND_W = 4;
   localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

   localparam logic [KIND_W-1:0] KIND_REDUCE = 4'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_SUB    = 4'd2;
   localparam logic [KIND_W-1:0] KIND_MUL    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DIV    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_NEG    = 4'd5;
   localparam logic [KIND_W-1:0] KIND_POW    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_INV    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_EQUAL  = 4'd8;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic signed [A_W-1:0]  operand_a;
      logic [B_W-1:0]         operand_b;
   } req_type;

   typedef struct packed {
      logic [MOD_W-1:0] result_value;
      logic             is_equal;
   } rsp_type;

   // handshake between sequencer and the shared reduction unit
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } red_ctl_type;

endpackage

// File: design/mau_reduce.sv
// mau_reduce: shared restoring remainder unit, one quotient bit per cycle
// depends on mau_pkg
`timescale 1ns / 1ps

module mau_reduce
   import mau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   dividend,
   input  logic [MOD_W-1:0] modulus,
   output red_ctl_type      ctl,
   output logic [MOD_W-1:0] remainder
);

   localparam int CNT_W = $clog2(A_W + 1);

   logic [A_W-1:0]   shift_ff, shift_in;
   logic [MOD_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MOD_W+1:0] trial;

   // shift in the next dividend bit, subtract the modulus when it fits
   always_comb begin
      trial    = {rem_ff, shift_ff[A_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CNT_W'(A_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[A_W-2:0], 1'b0};
         if (trial >= {1'b0, 1'b0, modulus})
            rem_in = (MOD_W+1)'(trial - {2'b00, modulus});
         else
            rem_in = trial[MOD_W:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign remainder = rem_ff[MOD_W-1:0];

endmodule

// File: design/mau_seq.sv
// mau_seq: operation sequencer; reduces operands, runs square-and-multiply
// depends on mau_pkg and the shared unit mau_reduce
`timescale 1ns / 1ps

module mau_seq
   import mau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [MOD_W-1:0] modulus,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_RED_A, S_WAIT_A, S_RED_B, S_WAIT_B, S_SIMPLE, S_SQR, S_SQR_W,
      S_MULB, S_MULB_W, S_FINAL, S_FINAL_W, S_OUT
   } state_type;

   localparam int BIT_W = $clog2(B_W);

   state_type        state_ff;
   req_type          req_ff;
   logic [MOD_W-1:0] m_ff;
   logic [MOD_W-1:0] a_ff, b_ff, acc_ff;
   logic [B_W-1:0]   exp_ff;
   logic [BIT_W-1:0] bit_ff;
   logic             neg_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic             red_start;
   logic [A_W-1:0]   red_din;
   red_ctl_type      red_ctl;
   logic [MOD_W-1:0] red_rem;
   logic [A_W-1:0]   prod;
   logic [MOD_W-1:0] a_mag_red;
   logic [MOD_W:0]   sum_w;
   logic [MOD_W:0]   dif_w;
   logic [MOD_W-1:0] simple_val;

   mau_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (red_din),
      .modulus   (m_ff),
      .ctl       (red_ctl),
      .remainder (red_rem)
   );

   // signed operand magnitude, then fold back for negative values
   assign a_mag_red = (neg_ff && red_rem != '0) ? m_ff - red_rem : red_rem;

   always_comb begin
      sum_w = {1'b0, a_ff} + {1'b0, b_ff};
      dif_w = {1'b0, a_ff} - {1'b0, b_ff};
      unique case (req_ff.kind)
         KIND_REDUCE: simple_val = a_ff;
         KIND_ADD:    simple_val = (sum_w >= {1'b0, m_ff}) ?
                                   MOD_W'(sum_w - {1'b0, m_ff}) : sum_w[MOD_W-1:0];
         KIND_SUB:    simple_val = dif_w[MOD_W] ? MOD_W'(dif_w + {1'b0, m_ff}) :
                                   dif_w[MOD_W-1:0];
         KIND_NEG:    simple_val = (a_ff == '0) ? '0 : m_ff - a_ff;
         default:     simple_val = '0;
      endcase
   end

   always_comb begin
      red_start = 1'b0;
      red_din   = '0;
      prod      = '0;
      unique case (state_ff)
         S_RED_A: begin
            red_start = 1'b1;
            red_din   = req_ff.operand_a[A_W-1] ? (~req_ff.operand_a + 1'b1)
                                                 : req_ff.operand_a;
         end
         S_RED_B: begin
            red_start = 1'b1;
            red_din   = {1'b0, req_ff.operand_b};
         end
         S_SQR: begin
            red_start = 1'b1;
            prod      = acc_ff * acc_ff;
            red_din   = prod;
         end
         S_MULB: begin
            red_start = 1'b1;
            prod      = acc_ff * b_ff;
            red_din   = prod;
         end
         S_FINAL: begin
            red_start = 1'b1;
            prod      = a_ff * acc_ff;
            red_din   = prod;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               req_ff   <= req_data;
               m_ff     <= (modulus < MOD_W'(2)) ? MOD_W'(1) : modulus;
               neg_ff   <= req_data.operand_a[A_W-1];
               state_ff <= S_RED_A;
            end
            S_RED_A:  state_ff <= S_WAIT_A;
            S_WAIT_A: if (red_ctl.done) begin
               a_ff     <= a_mag_red;
               neg_ff   <= 1'b0;
               state_ff <= S_RED_B;
            end
            S_RED_B:  state_ff <= S_WAIT_B;
            S_WAIT_B: if (red_ctl.done) begin
               bit_ff <= BIT_W'(B_W - 1);
               unique case (req_ff.kind)
                  KIND_POW: begin
                     b_ff     <= a_ff;
                     acc_ff   <= (m_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
                     exp_ff   <= req_ff.operand_b;
                     state_ff <= S_SQR;
                  end
                  KIND_INV: begin
                     b_ff     <= a_ff;
                     acc_ff   <= (m_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
                     exp_ff   <= (m_ff >= MOD_W'(2)) ? B_W'(m_ff - MOD_W'(2)) : '0;
                     state_ff <= S_SQR;
                  end
                  KIND_DIV: begin
                     b_ff     <= red_rem;
                     acc_ff   <= (m_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
                     exp_ff   <= (m_ff >= MOD_W'(2)) ? B_W'(m_ff - MOD_W'(2)) : '0;
                     state_ff <= S_SQR;
                  end
                  // plain product goes straight to the final multiply
                  KIND_MUL: begin
                     b_ff     <= red_rem;
                     acc_ff   <= red_rem;
                     state_ff <= S_FINAL;
                  end
                  default: begin
                     b_ff     <= red_rem;
                     acc_ff   <= (m_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
                     state_ff <= S_SIMPLE;
                  end
               endcase
            end
            S_SIMPLE: begin
               rsp_ff.result_value <= simple_val;
               rsp_ff.is_equal     <= (req_ff.kind == KIND_EQUAL) && (a_ff == b_ff);
               rsp_valid_ff        <= 1'b1;
               state_ff            <= S_OUT;
            end
            S_SQR:   state_ff <= S_SQR_W;
            S_SQR_W: if (red_ctl.done) begin
               acc_ff <= red_rem;
               if (exp_ff[bit_ff]) state_ff <= S_MULB;
               else if (bit_ff == '0) state_ff <= S_FINAL;
               else begin
                  bit_ff   <= bit_ff - 1'b1;
                  state_ff <= S_SQR;
               end
            end
            S_MULB:   state_ff <= S_MULB_W;
            S_MULB_W: if (red_ctl.done) begin
               acc_ff <= red_rem;
               if (bit_ff == '0) state_ff <= S_FINAL;
               else begin
                  bit_ff   <= bit_ff - 1'b1;
                  state_ff <= S_SQR;
               end
            end
            S_FINAL: begin
               if (req_ff.kind == KIND_DIV || req_ff.kind == KIND_MUL)
                  state_ff <= S_FINAL_W;
               else begin
                  rsp_ff.result_value <= acc_ff;
                  rsp_ff.is_equal     <= 1'b0;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_OUT;
               end
            end
            S_FINAL_W: if (red_ctl.done) begin
               rsp_ff.result_value <= red_rem;
               rsp_ff.is_equal     <= 1'b0;
               rsp_valid_ff        <= 1'b1;
               state_ff            <= S_OUT;
            end
            S_OUT: if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/modular_arithmetic_unit.sv
// modular_arithmetic_unit: top level, modulus register and operation sequencer
// depends on mau_pkg, mau_seq and mau_reduce
`timescale 1ns / 1ps
//
// Usage: one item on req (kind, operand_a, operand_b) gives one item on rsp
// (result_value, is_equal). Both channels use valid/stall; an item moves at an
// edge with valid high and stall low. req_stall is high from acceptance until
// the result item has been taken, so one item is in flight at a time.
// The modulus register is written through csr_write/csr_data; the user writes it
// only while idle, which the block itself does not enforce; reset loads 1000000007.
// All remainders go through one shared restoring reduction unit. Reduce, add,
// sub, neg and equal use two reductions; mul adds one multiply. Pow, inv and
// div run one squaring per exponent bit (63) plus one multiply per set bit.
// Div adds one more multiply.
// A stalled result holds in its output register until taken.
// Synchronous active-high reset returns the sequencer to idle.

module modular_arithmetic_unit
   import mau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [MOD_W-1:0] csr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic [MOD_W-1:0] modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= MODULUS_RESET;
      else if (csr_write) modulus_ff <= csr_data;
   end

   mau_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .modulus   (modulus_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open while result pending");
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.result_value == '0 || !rsp_data.is_equal))
      else $error("equal item with nonzero value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

// File: tb/modular_arithmetic_unit_checker.sv
// modular_arithmetic_unit_checker: watches the req, rsp and csr ports, predicts each result
// item from the current modulus and compares it field by field
// depends on mau_pkg
`timescale 1ns / 1ps

module modular_arithmetic_unit_checker
   import mau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [MOD_W-1:0] csr_data,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   output int               fail_count,
   output int               pending
);

   logic [MOD_W-1:0] modulus_copy;
   rsp_type          residue_queue[$];
   int               mismatches;

   function automatic longint unsigned reduce_signed(longint unsigned raw,
                                                     longint unsigned m);
      longint unsigned r;
      if (raw[63]) begin
         r = (64'd0 - raw) % m;
         return (r != 0) ? m - r : 64'd0;
      end
      return raw % m;
   endfunction

   function automatic longint unsigned power_mod(longint unsigned base,
                                                 longint unsigned e,
                                                 longint unsigned m);
      longint unsigned acc;
      acc = 64'd1 % m;
      for (int i = 62; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (e[i])
            acc = (acc * base) % m;
      end
      return acc;
   endfunction

   function automatic rsp_type predict_residue(req_type item, logic [MOD_W-1:0] modulus);
      longint unsigned m, a, b, e, v;
      rsp_type r;
      // a modulus below two behaves as one
      m = (modulus < 2) ? 64'd1 : 64'(modulus);
      e = 64'(item.operand_b);
      a = reduce_signed(64'(item.operand_a), m);
      b = e % m;
      v = 0;
      r = '0;
      case (item.kind)
         KIND_REDUCE: v = a;
         KIND_ADD:    v = (a + b) % m;
         KIND_SUB:    v = (a + m - b) % m;
         KIND_MUL:    v = (a * b) % m;
         KIND_DIV:    v = (a * power_mod(b, (m >= 2) ? m - 2 : 0, m)) % m;
         KIND_NEG:    v = (m - a) % m;
         KIND_POW:    v = power_mod(a, e, m);
         KIND_INV:    v = power_mod(a, (m >= 2) ? m - 2 : 0, m);
         KIND_EQUAL:  r.is_equal = (a == b);
         default:     v = 0;
      endcase
      r.result_value = v[MOD_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         modulus_copy = MODULUS_RESET;
         residue_queue.delete();
         mismatches = 0;
      end else begin
         if (csr_write)
            modulus_copy = csr_data;
         if (req_valid && !req_stall)
            residue_queue.push_back(predict_residue(req_data, modulus_copy));
         if (rsp_valid && !rsp_stall) begin
            if (residue_queue.size() == 0) begin
               $error("unexpected result item: result_value %0d is_equal %0d",
                      rsp_data.result_value, rsp_data.is_equal);
               mismatches++;
            end else begin
               want = residue_queue.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, actual %0d",
                         want.result_value, rsp_data.result_value);
                  mismatches++;
               end
               if (rsp_data.is_equal !== want.is_equal) begin
                  $error("is_equal: expected %0d, actual %0d",
                         want.is_equal, rsp_data.is_equal);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending <= residue_queue.size();
   end

endmodule

// File: tb/modular_arithmetic_unit_tb.sv
// modular_arithmetic_unit_tb: clock, reset and stimulus for the modular arithmetic unit,
// with modulus phases and random stalls; verdict from the checker's failure count
// depends on mau_pkg, modular_arithmetic_unit and modular_arithmetic_unit_checker
`timescale 1ns / 1ps

module modular_arithmetic_unit_tb;
   import mau_pkg::*;

   localparam longint CYCLE_LIMIT = 40000000;

   logic             clock;
   logic             reset;
   logic             csr_write;
   logic [MOD_W-1:0] csr_data;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   int               fail_count;
   int               pending;
   longint           cycles;
   int               items_sent;
   int               moduli_used;
   bit               hold_rsp;

   modular_arithmetic_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   modular_arithmetic_unit_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   // result side: random stalls, with a long hold on request
   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   function automatic logic [63:0] pick_operand_a();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'($signed($urandom_range(0, 200)) - 100);
         2: return 64'($urandom);
         3: return {1'b1, 63'($urandom)};
         4: return {1'b0, 31'($urandom), $urandom};
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   function automatic logic [B_W-1:0] pick_operand_b();
      case ($urandom_range(0, 3))
         0: return B_W'({$urandom, $urandom});
         1: return B_W'($urandom_range(0, 40));
         2: return B_W'($urandom);
         default: return B_W'({$urandom, $urandom} >> $urandom_range(1, 63));
      endcase
   endfunction

   task automatic send_item(logic [KIND_W-1:0] kind, logic [63:0] a, logic [B_W-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: kind, operand_a: a, operand_b: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random(int count);
      logic [KIND_W-1:0] kind;
      int p;
      for (int i = 0; i < count; i++) begin
         // exponent-driven kinds are slow, so keep them a minority
         p = $urandom_range(0, 99);
         if (p < 5) kind = KIND_POW;
         else if (p < 9) kind = KIND_INV;
         else if (p < 13) kind = KIND_DIV;
         else if (p < 17) kind = KIND_EQUAL + KIND_W'($urandom_range(1, 7));
         else begin
            case ($urandom_range(0, 5))
               0: kind = KIND_REDUCE;
               1: kind = KIND_ADD;
               2: kind = KIND_SUB;
               3: kind = KIND_MUL;
               4: kind = KIND_NEG;
               default: kind = KIND_EQUAL;
            endcase
         end
         send_item(kind, pick_operand_a(), pick_operand_b());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_modulus(logic [MOD_W-1:0] value);
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      moduli_used++;
   endtask

   task automatic modulus_phase(logic [MOD_W-1:0] value, int count);
      logic [63:0] b;
      write_modulus(value);
      // equal reduced operands, a div and an inv, then random items
      b = 64'($urandom_range(0, 1000));
      send_item(KIND_EQUAL, b + 64'(value), B_W'(b));
      send_item(KIND_DIV, 64'd5, '0);
      send_item(KIND_INV, 64'd3, '0);
      send_random(count);
      drain();
   endtask

   initial begin
      items_sent = 0;
      moduli_used = 0;
      hold_rsp = 0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_data = '0;
      req_valid = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset modulus
      send_item(KIND_REDUCE, 64'h8000_0000_0000_0000, '0);
      send_item(KIND_REDUCE, 64'h7fff_ffff_ffff_ffff, '1);
      send_item(KIND_REDUCE, '1, '0);
      send_item(KIND_ADD, '1, '1);
      send_item(KIND_SUB, 64'd0, '1);
      send_item(KIND_SUB, 64'h8000_0000_0000_0000, 63'd1000000007);
      send_item(KIND_MUL, 64'h7fff_ffff_ffff_ffff, '1);
      send_item(KIND_MUL, '1, 63'd1000000006);
      send_item(KIND_NEG, 64'd0, '0);
      send_item(KIND_NEG, '1, '0);
      send_item(KIND_POW, 64'd0, '0);
      send_item(KIND_POW, 64'd7, '0);
      send_item(KIND_POW, '1, '1);
      send_item(KIND_POW, 64'h8000_0000_0000_0000, 63'd1000000006);
      send_item(KIND_INV, 64'd0, '0);
      send_item(KIND_INV, 64'd2, '0);
      send_item(KIND_DIV, 64'd10, '0);
      send_item(KIND_DIV, '1, 63'd3);
      send_item(KIND_EQUAL, 64'd1000000008, 63'd1);
      send_item(KIND_EQUAL, '1, 63'd1000000006);
      send_item(KIND_EQUAL, 64'd5, 63'd6);
      send_item(KIND_EQUAL + 4'd1, '1, '1);
      send_item('1, '1, '1);
      drain();

      // long hold on the result side while items keep coming
      hold_rsp = 1;
      send_random(4);
      send_random(130);
      drain();

      modulus_phase(31'h7fff_ffff, 100);
      modulus_phase(31'd2, 50);
      modulus_phase(31'd0, 35);
      modulus_phase(31'd1, 30);
      modulus_phase(31'd7, 50);
      modulus_phase(31'd15, 40);
      modulus_phase(31'd3, 30);
      modulus_phase(31'($urandom_range(2, 32'h7fff_ffff)), 50);
      modulus_phase(MODULUS_RESET, 30);

      $display("sent %0d items over %0d modulus settings, %0d cycles",
               items_sent, moduli_used + 1, cycles);
      $display("covered every operation, unused kinds, operand extremes and tiny moduli");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
design/mau_pkg.sv
design/mau_reduce.sv
design/mau_seq.sv
design/modular_arithmetic_unit.sv
tb/modular_arithmetic_unit_checker.sv
tb/modular_arithmetic_unit_tb.sv
